// ----- hdl/tkc_pkg.sv -----
// Shared types and constants for the three-register keystream cipher.
// Used by tkc_front, tkc_back and the top level; depends on nothing else.

package tkc_pkg;

  // Register lengths in bytes.
  localparam int unsigned SHORT_LEN  = 7;
  localparam int unsigned MIDDLE_LEN = 9;
  localparam int unsigned LONG_LEN   = 11;

  // Flat key position boundaries.
  localparam logic [4:0] MIDDLE_BASE = 5'd7;
  localparam logic [4:0] LONG_BASE   = 5'd16;
  localparam logic [4:0] POS_LAST    = 5'd26;

  // Feedback taps of each register.
  localparam int unsigned SHORT_TAP0  = 0;
  localparam int unsigned SHORT_TAP1  = 2;
  localparam int unsigned SHORT_TAP2  = 4;
  localparam int unsigned MIDDLE_TAP0 = 2;
  localparam int unsigned MIDDLE_TAP1 = 4;
  localparam int unsigned MIDDLE_TAP2 = 6;
  localparam int unsigned LONG_TAP0   = 4;
  localparam int unsigned LONG_TAP1   = 6;
  localparam int unsigned LONG_TAP2   = 8;

  // Constant mixed into every new tail byte and into the keystream sum.
  localparam logic [7:0] FEED_CONST = 8'h01;

  // Result queue depth.
  localparam int unsigned RES_DEPTH = 4;

  // Input operation codes.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_CIPHER = 1'b1
  } tkc_op_t;

  // Which shift register a load targets.
  typedef enum logic [1:0] {
    SEL_SHORT  = 2'd0,
    SEL_MIDDLE = 2'd1,
    SEL_LONG   = 2'd2
  } tkc_sel_t;

  // One classified command passed from the front to the back.
  typedef struct packed {
    tkc_op_t    kind;
    tkc_sel_t   sel;
    logic [3:0] idx;
    logic [7:0] data;
  } tkc_cmd_t;

endpackage

// ----- hdl/tkc_front.sv -----
// Front part of the cipher: accepts input beats, classifies them and
// holds them in a two-entry command queue. Depends on tkc_pkg.

module tkc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              op,
  input  logic [4:0]        key_position,
  input  logic [7:0]        data_byte,
  output logic              cmd_valid,
  output tkc_pkg::tkc_cmd_t cmd,
  input  logic              cmd_pop
);

  tkc_pkg::tkc_cmd_t q_mem [2];
  logic [1:0]        q_count;
  logic              q_wr;
  logic              q_rd;
  logic [1:0]        q_count_next;

  tkc_pkg::tkc_cmd_t cls;
  logic              cls_keep;
  logic              accept;
  logic              enq;

  // Classify the incoming beat; out-of-range loads are dropped here.
  always_comb begin
    cls.kind = tkc_pkg::tkc_op_t'(op);
    cls.data = data_byte;
    cls.sel  = tkc_pkg::SEL_SHORT;
    cls.idx  = key_position[3:0];
    cls_keep = 1'b1;
    if (cls.kind == tkc_pkg::OP_LOAD) begin
      if (key_position inside {[5'd0 : tkc_pkg::MIDDLE_BASE - 5'd1]}) begin
        cls.sel = tkc_pkg::SEL_SHORT;
        cls.idx = key_position[3:0];
      end else if (key_position inside {[tkc_pkg::MIDDLE_BASE : tkc_pkg::LONG_BASE - 5'd1]}) begin
        cls.sel = tkc_pkg::SEL_MIDDLE;
        cls.idx = 4'(key_position - tkc_pkg::MIDDLE_BASE);
      end else if (key_position inside {[tkc_pkg::LONG_BASE : tkc_pkg::POS_LAST]}) begin
        cls.sel = tkc_pkg::SEL_LONG;
        cls.idx = 4'(key_position - tkc_pkg::LONG_BASE);
      end else begin
        cls_keep = 1'b0;
      end
    end
  end

  // Handshake and queue occupancy.
  assign full      = (q_count == 2'd2);
  assign accept    = push && !full;
  assign enq       = accept && cls_keep;
  assign cmd_valid = (q_count != 2'd0);
  assign cmd       = q_mem[q_rd];

  always_comb begin
    q_count_next = q_count;
    if (enq && !(cmd_pop && cmd_valid)) begin
      q_count_next = q_count + 2'd1;
    end else if (!enq && cmd_pop && cmd_valid) begin
      q_count_next = q_count - 2'd1;
    end
  end

  // Queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
    end else begin
      q_count <= q_count_next;
      if (enq) begin
        q_wr <= ~q_wr;
      end
      if (cmd_pop && cmd_valid) begin
        q_rd <= ~q_rd;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[q_wr] <= cls;
    end
  end

endmodule

// ----- hdl/tkc_back.sv -----
// Back part of the cipher: the three key shift registers, the two-stage
// keystream combiner and the four-entry result queue. Depends on tkc_pkg.

module tkc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  tkc_pkg::tkc_cmd_t cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte
);

  logic [7:0] short_reg  [tkc_pkg::SHORT_LEN];
  logic [7:0] middle_reg [tkc_pkg::MIDDLE_LEN];
  logic [7:0] long_reg   [tkc_pkg::LONG_LEN];

  logic       is_cipher;
  logic       room;
  logic       do_load;
  logic       do_cipher;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [15:0] ab_wide;
  logic [15:0] ac_wide;

  logic       s1_valid;
  logic [7:0] s1_ab;
  logic [7:0] s1_ac;
  logic [7:0] s1_c;
  logic [7:0] s1_data;
  logic [15:0] abc_wide;
  logic [7:0] ks;

  logic [7:0] r_mem [tkc_pkg::RES_DEPTH];
  logic [$clog2(tkc_pkg::RES_DEPTH)-1:0] r_wr;
  logic [$clog2(tkc_pkg::RES_DEPTH)-1:0] r_rd;
  logic [$clog2(tkc_pkg::RES_DEPTH):0]   r_count;
  logic [$clog2(tkc_pkg::RES_DEPTH):0]   r_count_next;
  logic       r_pop;

  // Issue control: a cipher beat needs a free result slot counting the one in flight.
  assign is_cipher = (cmd.kind == tkc_pkg::OP_CIPHER);
  assign room      = (r_count + {{$clog2(tkc_pkg::RES_DEPTH){1'b0}}, s1_valid})
                     < ($clog2(tkc_pkg::RES_DEPTH)+1)'(tkc_pkg::RES_DEPTH);
  assign do_load   = cmd_valid && !is_cipher;
  assign do_cipher = cmd_valid && is_cipher && room;
  assign cmd_pop   = do_load || do_cipher;

  // Head bytes and the first level of products.
  assign a       = short_reg[0];
  assign b       = middle_reg[0];
  assign c       = long_reg[0];
  assign ab_wide = a * b;
  assign ac_wide = a * c;

  // Key shift registers: load one byte or shift all three by one byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tkc_pkg::SHORT_LEN; i++) short_reg[i] <= 8'd0;
      for (int i = 0; i < tkc_pkg::MIDDLE_LEN; i++) middle_reg[i] <= 8'd0;
      for (int i = 0; i < tkc_pkg::LONG_LEN; i++) long_reg[i] <= 8'd0;
    end else if (do_load) begin
      case (cmd.sel)
        tkc_pkg::SEL_SHORT:  short_reg[cmd.idx[2:0]] <= cmd.data;
        tkc_pkg::SEL_MIDDLE: middle_reg[cmd.idx] <= cmd.data;
        tkc_pkg::SEL_LONG:   long_reg[cmd.idx] <= cmd.data;
        default: ;
      endcase
    end else if (do_cipher) begin
      for (int i = 0; i < tkc_pkg::SHORT_LEN - 1; i++) short_reg[i] <= short_reg[i+1];
      for (int i = 0; i < tkc_pkg::MIDDLE_LEN - 1; i++) middle_reg[i] <= middle_reg[i+1];
      for (int i = 0; i < tkc_pkg::LONG_LEN - 1; i++) long_reg[i] <= long_reg[i+1];
      short_reg[tkc_pkg::SHORT_LEN-1] <= short_reg[tkc_pkg::SHORT_TAP0]
        ^ short_reg[tkc_pkg::SHORT_TAP1] ^ short_reg[tkc_pkg::SHORT_TAP2]
        ^ tkc_pkg::FEED_CONST;
      middle_reg[tkc_pkg::MIDDLE_LEN-1] <= middle_reg[tkc_pkg::MIDDLE_TAP0]
        ^ middle_reg[tkc_pkg::MIDDLE_TAP1] ^ middle_reg[tkc_pkg::MIDDLE_TAP2]
        ^ tkc_pkg::FEED_CONST;
      long_reg[tkc_pkg::LONG_LEN-1] <= long_reg[tkc_pkg::LONG_TAP0]
        ^ long_reg[tkc_pkg::LONG_TAP1] ^ long_reg[tkc_pkg::LONG_TAP2]
        ^ tkc_pkg::FEED_CONST;
    end
  end

  // Stage one: register the partial products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= do_cipher;
    end
  end

  always_ff @(posedge clk) begin
    if (do_cipher) begin
      s1_ab   <= ab_wide[7:0];
      s1_ac   <= ac_wide[7:0];
      s1_c    <= c;
      s1_data <= cmd.data;
    end
  end

  // Stage two: abc + ab + ac + 1, modulo 256, then mix with the data byte.
  assign abc_wide = s1_ab * s1_c;
  assign ks       = abc_wide[7:0] + s1_ab + s1_ac + tkc_pkg::FEED_CONST;

  // Result queue.
  assign empty    = (r_count == '0);
  assign r_pop    = pop && !empty;
  assign out_byte = r_mem[r_rd];

  always_comb begin
    r_count_next = r_count;
    if (s1_valid && !r_pop) begin
      r_count_next = r_count + ($clog2(tkc_pkg::RES_DEPTH)+1)'(1);
    end else if (!s1_valid && r_pop) begin
      r_count_next = r_count - ($clog2(tkc_pkg::RES_DEPTH)+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_count <= '0;
      r_wr    <= '0;
      r_rd    <= '0;
    end else begin
      r_count <= r_count_next;
      if (s1_valid) begin
        r_wr <= r_wr + ($clog2(tkc_pkg::RES_DEPTH))'(1);
      end
      if (r_pop) begin
        r_rd <= r_rd + ($clog2(tkc_pkg::RES_DEPTH))'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      r_mem[r_wr] <= s1_data ^ ks;
    end
  end

  // The result queue never overflows.
  assert property (@(posedge clk) disable iff (rst)
    r_count <= ($clog2(tkc_pkg::RES_DEPTH)+1)'(tkc_pkg::RES_DEPTH))
    else $error("result queue over capacity");

  // A beat in the combiner always finds a free result slot.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (r_count < ($clog2(tkc_pkg::RES_DEPTH)+1)'(tkc_pkg::RES_DEPTH)))
    else $error("combiner result has no queue slot");

  // A cipher issue shows up in the combiner on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    do_cipher |=> s1_valid)
    else $error("cipher beat lost between issue and combiner");

  // Commands are only taken from the queue when one is present.
  assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

// ----- hdl/three_register_keystream_cipher_core.sv -----
// A cipher beat passes the command queue, stage one and the result queue in turn.
// Throughput: one beat per cycle in both directions while full is low; the back end
// issues one command per cycle; ciphers wait for a slot in the four-entry result queue.
// Load beats give no result; loads to positions beyond 26 are dropped at the front.
// Reset (rst, synchronous) clears all three key registers to zero and empties both queues.
// Top level: connects tkc_front and tkc_back; depends on tkc_pkg.

module three_register_keystream_cipher_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       op,
  input  logic [4:0] key_position,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte
);

  logic              cmd_valid;
  logic              cmd_pop;
  tkc_pkg::tkc_cmd_t cmd;

  // Front: accept and classify.
  tkc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .key_position (key_position),
    .data_byte    (data_byte),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: key registers, keystream and results.
  tkc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte)
  );

endmodule
